[rtl/core/bba_pkg.sv]
package bba_pkg;

   typedef struct packed {
      logic        req_type;
      logic [20:0] req_size;
      logic [19:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [19:0] block_offset;
      logic [3:0]  block_level;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RANGE   = 2'd2,
      CMD_BADFREE = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   level;
      logic [19:0]  offset;
   } cmd_type;

   localparam logic       REQ_ALLOC = 1'b0;

   localparam logic [2:0] ST_ALLOC   = 3'd0;
   localparam logic [2:0] ST_FREED   = 3'd1;
   localparam logic [2:0] ST_NOMEM   = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_BADFREE = 3'd4;

   localparam logic [3:0]  OWNER_NONE   = 4'd15;
   localparam logic [21:0] HEADER_BYTES = 22'd8;
   localparam logic [21:0] SMALL_LIMIT  = 22'd128;

endpackage

[rtl/core/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/bba_fifo.sv]
module bba_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

[rtl/core/bba_front.sv]
module bba_front #(
   parameter int LEVELS         = 13,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input  bba_pkg::req_word_type req_word,
   output bba_pkg::cmd_type      cmd
);

   localparam int POOL_LOG2 = MIN_BLOCK_LOG2 + LEVELS - 1;

   logic [21:0] total;
   logic [21:0] tm1;
   logic [4:0]  p;
   logic        bad_range;
   logic        bad_off;

   always_comb begin
      total = req_word.req_size + bba_pkg::HEADER_BYTES;
      tm1   = total - 22'd1;
      p     = 5'd0;
      for (int i = 0; i < 22; i++) begin
         if (tm1[i]) begin
            p = 5'(i + 1);
         end
      end
      bad_range = (total <= bba_pkg::SMALL_LIMIT) ||
                  (33'(total) > (33'd1 << POOL_LOG2));
      bad_off   = ((32'(req_word.free_offset) >> POOL_LOG2) != 32'd0) ||
                  ((32'(req_word.free_offset) & ((32'd1 << MIN_BLOCK_LOG2) - 32'd1)) != 32'd0);

      cmd.offset = req_word.free_offset;
      cmd.level  = (32'(p) > 32'(MIN_BLOCK_LOG2)) ? 4'(32'(p) - 32'(MIN_BLOCK_LOG2)) : 4'd0;
      if (req_word.req_type == bba_pkg::REQ_ALLOC) begin
         cmd.kind = bad_range ? bba_pkg::CMD_RANGE : bba_pkg::CMD_ALLOC;
      end else begin
         cmd.kind = bad_off ? bba_pkg::CMD_BADFREE : bba_pkg::CMD_FREE;
      end
   end

endmodule

[rtl/core/bba_back.sv]
module bba_back #(
   parameter int LEVELS         = 13,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::cmd_type      cmd,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output bba_pkg::rsp_word_type rsp,
   output logic                  rsp_push,
   input  logic                  rsp_full
);

   localparam int NW          = LEVELS;
   localparam int SW          = LEVELS - 1;
   localparam int MAP_NODES   = (1 << LEVELS) - 1;
   localparam int OWNER_SLOTS = 1 << (LEVELS - 1);
   localparam logic [3:0] TOP = 4'(LEVELS - 1);

   typedef enum logic [11:0] {
      S_CLEAR     = 12'b000000000001,
      S_IDLE      = 12'b000000000010,
      S_SCAN      = 12'b000000000100,
      S_SCAN_CHK  = 12'b000000001000,
      S_SPLIT     = 12'b000000010000,
      S_OWN       = 12'b000000100000,
      S_FREE_CHK  = 12'b000001000000,
      S_MERGE     = 12'b000010000000,
      S_MERGE_CHK = 12'b000100000000,
      S_PLACE     = 12'b001000000000,
      S_DONE      = 12'b010000000000,
      S_WAIT      = 12'b100000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [NW-1:0]         node_ff, node_in;
   logic [NW-1:0]         start_ff, start_in;
   logic [3:0]            lvl_ff, lvl_in;
   logic [3:0]            need_ff, need_in;
   logic [SW-1:0]         slot_ff, slot_in;
   bba_pkg::rsp_word_type res_ff, res_in;

   logic                  map_we, map_wdata, map_rdata;
   logic [NW-1:0]         map_waddr, map_raddr;
   logic                  own_we;
   logic [SW-1:0]         own_waddr, own_raddr;
   logic [3:0]            own_wdata, own_rdata;
   logic [NW-1:0]         sib, rel;

   bba_ram #(.WIDTH(1), .DEPTH(MAP_NODES)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr(map_raddr), .rdata(map_rdata)
   );

   bba_ram #(.WIDTH(4), .DEPTH(OWNER_SLOTS)) u_own (
      .clock(clock), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
      .raddr(own_raddr), .rdata(own_rdata)
   );

   assign rsp = res_ff;
   assign sib = node_ff[0] ? node_ff + NW'(1) : node_ff - NW'(1);
   assign rel = node_ff - start_ff;

   always_comb begin
      state_in  = state_ff;
      node_in   = node_ff;
      start_in  = start_ff;
      lvl_in    = lvl_ff;
      need_in   = need_ff;
      slot_in   = slot_ff;
      res_in    = res_ff;
      map_we    = 1'b0;
      map_waddr = node_ff;
      map_wdata = 1'b0;
      map_raddr = node_ff;
      own_we    = 1'b0;
      own_waddr = slot_ff;
      own_wdata = bba_pkg::OWNER_NONE;
      own_raddr = SW'(32'(cmd.offset) >> MIN_BLOCK_LOG2);
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // node_ff doubles as the sweep counter
            map_we    = 1'b1;
            map_wdata = node_ff == '0;
            own_we    = !node_ff[NW-1];
            own_waddr = node_ff[SW-1:0];
            node_in   = node_ff + NW'(1);
            if (node_ff == NW'(MAP_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               res_in  = '0;
               slot_in = SW'(32'(cmd.offset) >> MIN_BLOCK_LOG2);
               case (cmd.kind)
                  bba_pkg::CMD_RANGE: begin
                     res_in.status = bba_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end
                  bba_pkg::CMD_BADFREE: begin
                     res_in.status = bba_pkg::ST_BADFREE;
                     state_in      = S_DONE;
                  end
                  bba_pkg::CMD_ALLOC: begin
                     need_in  = cmd.level;
                     lvl_in   = cmd.level;
                     start_in = (NW'(1) << (TOP - cmd.level)) - NW'(1);
                     node_in  = (NW'(1) << (TOP - cmd.level)) - NW'(1);
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in.block_offset = cmd.offset;
                     state_in            = S_FREE_CHK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (map_rdata) begin
               map_we   = 1'b1;
               state_in = (lvl_ff == need_ff) ? S_OWN : S_SPLIT;
            end else if (node_ff == {start_ff[NW-2:0], 1'b0}) begin
               if (lvl_ff == TOP) begin
                  res_in.status = bba_pkg::ST_NOMEM;
                  state_in      = S_DONE;
               end else begin
                  lvl_in   = lvl_ff + 4'd1;
                  start_in = start_ff >> 1;
                  node_in  = start_ff >> 1;
                  state_in = S_SCAN;
               end
            end else begin
               node_in  = node_ff + NW'(1);
               state_in = S_SCAN;
            end
         end
         S_SPLIT: begin
            // upper half goes free, carry on with the lower half
            map_we    = 1'b1;
            map_waddr = {node_ff[NW-2:0], 1'b0} + NW'(2);
            map_wdata = 1'b1;
            node_in   = {node_ff[NW-2:0], 1'b1};
            start_in  = {start_ff[NW-2:0], 1'b1};
            lvl_in    = lvl_ff - 4'd1;
            if (lvl_ff - 4'd1 == need_ff) begin
               state_in = S_OWN;
            end
         end
         S_OWN: begin
            own_we              = 1'b1;
            own_waddr           = SW'(rel) << lvl_ff;
            own_wdata           = lvl_ff;
            res_in.status       = bba_pkg::ST_ALLOC;
            res_in.block_offset = 20'(32'(rel) << (MIN_BLOCK_LOG2 + 32'(lvl_ff)));
            res_in.block_level  = lvl_ff;
            state_in            = S_DONE;
         end
         S_FREE_CHK: begin
            if (own_rdata == bba_pkg::OWNER_NONE || own_rdata > TOP) begin
               res_in.status       = bba_pkg::ST_BADFREE;
               res_in.block_offset = '0;
               state_in            = S_DONE;
            end else begin
               own_we             = 1'b1;
               lvl_in             = own_rdata;
               res_in.status      = bba_pkg::ST_FREED;
               res_in.block_level = own_rdata;
               start_in           = (NW'(1) << (TOP - own_rdata)) - NW'(1);
               node_in            = (NW'(1) << (TOP - own_rdata)) - NW'(1)
                                    + NW'(slot_ff >> own_rdata);
               state_in           = (own_rdata == TOP) ? S_PLACE : S_MERGE;
            end
         end
         S_MERGE: begin
            map_raddr = sib;
            state_in  = S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            if (map_rdata) begin
               map_we    = 1'b1;
               map_waddr = sib;
               node_in   = (node_ff - NW'(1)) >> 1;
               lvl_in    = lvl_ff + 4'd1;
               state_in  = (lvl_ff + 4'd1 == TOP) ? S_PLACE : S_MERGE;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            map_we    = 1'b1;
            map_wdata = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         node_ff  <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
      end
      start_ff <= start_in;
      lvl_ff   <= lvl_in;
      need_ff  <= need_in;
      slot_ff  <= slot_in;
      res_ff   <= res_in;
   end

endmodule

[rtl/core/buddy_block_allocator.sv]
// channel   ports                               word type
// request   push, full, req_word                bba_pkg::req_word_type
// response  pop, empty, rsp_word                bba_pkg::rsp_word_type
//
// Requests are classified on entry and queued (two words) for the engine.
// Allocate: the map is scanned from the smallest fitting level upward, and the
// block found is split down to that level; free: buddies are checked and merged
// upward. Each queue holds its words in registers. Rejected requests skip the map.
// After reset a clearing pass over all 2^LEVELS - 1 map entries (8191 by default)
// runs before the first request is served; requests still queue meanwhile.
// Up to two responses wait in the output queue; the engine stalls when full.
module buddy_block_allocator #(
   parameter int LEVELS         = 13,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  bba_pkg::req_word_type req_word,
   input  logic                  pop,
   output logic                  empty,
   output bba_pkg::rsp_word_type rsp_word
);

   bba_pkg::cmd_type      cmd_in_w, cmd_out_w;
   logic                  cmd_empty, cmd_pop;
   bba_pkg::rsp_word_type rsp_w;
   logic                  rsp_push, rsp_full;

   bba_front #(.LEVELS(LEVELS), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)) u_front (
      .req_word(req_word), .cmd(cmd_in_w)
   );

   bba_fifo #(.WIDTH($bits(bba_pkg::cmd_type))) u_cmdq (
      .clock(clock), .reset(reset), .push(push), .wdata(cmd_in_w), .full(full),
      .pop(cmd_pop), .rdata(cmd_out_w), .empty(cmd_empty)
   );

   bba_back #(.LEVELS(LEVELS), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)) u_back (
      .clock(clock), .reset(reset), .cmd(cmd_out_w), .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop), .rsp(rsp_w), .rsp_push(rsp_push), .rsp_full(rsp_full)
   );

   bba_fifo #(.WIDTH($bits(bba_pkg::rsp_word_type))) u_rspq (
      .clock(clock), .reset(reset), .push(rsp_push), .wdata(rsp_w), .full(rsp_full),
      .pop(pop), .rdata(rsp_word), .empty(empty)
   );

endmodule

[rtl/core/bba_checker.sv]
module bba_checker #(
   parameter int LEVELS         = 13,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  pop,
   input logic                  empty,
   input bba_pkg::rsp_word_type rsp_word
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_word.status <= bba_pkg::ST_BADFREE)
      else $error("bad status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_word.status == bba_pkg::ST_NOMEM ||
                  rsp_word.status == bba_pkg::ST_RANGE ||
                  rsp_word.status == bba_pkg::ST_BADFREE))
      |-> (rsp_word.block_offset == '0 && rsp_word.block_level == '0))
      else $error("error word carries a block");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.status == bba_pkg::ST_ALLOC) |->
      (32'(rsp_word.block_level) <= LEVELS - 1 &&
       (32'(rsp_word.block_offset) &
        ((32'd1 << (MIN_BLOCK_LOG2 + 32'(rsp_word.block_level))) - 32'd1)) == 32'd0))
      else $error("misaligned block");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("waiting word changed");

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("word after reset");

endmodule

bind buddy_block_allocator bba_checker #(
   .LEVELS(LEVELS), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)
) u_bba_checker (
   .clock(clock), .reset(reset), .pop(pop), .empty(empty), .rsp_word(rsp_word)
);
